// ===== sv/stt_pkg.sv =====
// shared types and constants of the sorted timeout timer pool
`timescale 1ns / 1ps
package stt_pkg;
    localparam logic [2:0] OP_ALLOC   = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_BIND    = 3'd2;
    localparam logic [2:0] OP_ARM     = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;

    localparam logic [2:0] K_ALLOC   = 3'd0;
    localparam logic [2:0] K_FAIL    = 3'd1;
    localparam logic [2:0] K_EVENT   = 3'd2;
    localparam logic [2:0] K_SWITCH  = 3'd3;
    localparam logic [2:0] K_DONE    = 3'd4;
    localparam logic [2:0] K_REJECT  = 3'd5;

    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    localparam logic [31:0] NEVER     = 32'hffffffff;
    localparam logic [31:0] COUNT_MAX = 32'hfffffffe;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  slot;
        logic [3:0]  target_queue;
        logic [31:0] event_value;
        logic        last;
    } result_t;
endpackage

// ===== sv/stt_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/sorted_timeout_timer_pool.sv =====
// top level of the sorted timeout timer pool
`timescale 1ns / 1ps
// Timer pool of NUM_TIMERS entries kept in a sorted linked list. Deadline and
// successor of each entry share one RAM word, queue and value sit in a second
// RAM, both with registered read; the per-entry status is in flip-flops.
// Allocate, release and bind pass from idle through the output state. Arm walks
// the list one RAM read per node. A tick walks the due timers through a read and
// a data state each and emits one result beat per expiry, but for the task timer,
// whose expiry gives a single switch beat after the walk; a result waits in an
// output register while the next operation may start. Index codes in timer_index
// not below NUM_TIMERS are rejected. After reset the block writes the sentinel
// deadline and clears the other deadlines before it takes the first item.
module sorted_timeout_timer_pool #(
    parameter int NUM_TIMERS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[2:0], timer_index[7:3], delay[39:8], destination[43:40],
    // payload[75:44], zero fill [79:76]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // kind[2:0], slot[7:3], target_queue[11:8], event_value[43:12], zero [47:44]
    output logic [47:0] m_tdata,
    output logic        m_tlast
);
    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int DSW = 32 + AW;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_AH    = 4'd2;  // arm: head entry arrived
    localparam logic [3:0] S_AS    = 4'd4;  // arm: link new entry to its successor
    localparam logic [3:0] S_AD    = 4'd5;  // arm: next entry arrived
    localparam logic [3:0] S_TR    = 4'd6;  // tick: read cur
    localparam logic [3:0] S_TD    = 4'd7;  // tick: data arrived
    localparam logic [3:0] S_TSW   = 4'd8;
    localparam logic [3:0] S_TDONE = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10; // single result pending

    logic [3:0]  state_reg, state_next;
    logic [4:0]  task_reg;
    logic [1:0]  status_reg [NUM_TIMERS];
    logic [AW-1:0] head_reg, head_next;
    logic [31:0] tick_reg, tick_next;
    logic [31:0] early_reg, early_next;
    logic [AW:0] init_reg;
    logic [AW-1:0] idx_reg, idx_next, cur_reg, cur_next, prev_reg, prev_next;
    logic [31:0] dl_reg, dl_next;
    logic [31:0] pdl_reg, pdl_next;
    logic        sw_reg, sw_next;
    logic [6:0]  cnt_reg, cnt_next;
    stt_pkg::result_t res_reg, res_next, pend_reg, pend_next;
    logic        mv_reg, mv_next;

    // input fields
    logic [2:0]  in_op;
    logic [4:0]  in_ti;
    logic [31:0] in_delay;
    logic [3:0]  in_dest;
    logic [31:0] in_pay;
    assign in_op    = s_tdata[2:0];
    assign in_ti    = s_tdata[7:3];
    assign in_delay = s_tdata[39:8];
    assign in_dest  = s_tdata[43:40];
    assign in_pay   = s_tdata[75:44];

    // rams: deadline with successor, queue with value
    logic           ds_we, qv_we;
    logic [AW-1:0]  ds_wa, qv_wa, ds_ra, qv_ra;
    logic [DSW-1:0] ds_wd, ds_rd;
    logic [35:0]    qv_wd, qv_rd;
    logic [31:0]    rd_dl;
    logic [AW-1:0]  rd_sc;

    stt_ram #(.WIDTH(DSW), .DEPTH(NUM_TIMERS)) u_ds (
        .aclk(aclk), .we(ds_we), .waddr(ds_wa), .wdata(ds_wd),
        .raddr(ds_ra), .rdata(ds_rd));
    stt_ram #(.WIDTH(36), .DEPTH(NUM_TIMERS)) u_qv (
        .aclk(aclk), .we(qv_we), .waddr(qv_wa), .wdata(qv_wd),
        .raddr(qv_ra), .rdata(qv_rd));

    assign rd_dl = ds_rd[DSW-1:AW];
    assign rd_sc = ds_rd[AW-1:0];

    logic in_ok;
    logic [AW-1:0] ti_a;
    assign in_ok = ({27'd0, in_ti} < NUM_TIMERS);
    assign ti_a  = AW'(in_ti);

    // lowest free entry
    logic          free_any;
    logic [AW-1:0] free_idx;
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (status_reg[i] == stt_pkg::ST_FREE) begin
                free_any = 1'b1;
                free_idx = AW'(i);
            end
        end
    end

    logic out_free;
    assign out_free = !mv_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    logic [31:0] sum;
    logic        carry;
    assign {carry, sum} = {1'b0, in_delay} + {1'b0, tick_reg};

    // status register writes
    logic          st_we;
    logic [AW-1:0] st_wa;
    logic [1:0]    st_wd;

    function automatic stt_pkg::result_t mk(input logic [2:0] k, input logic l);
        stt_pkg::result_t r;
        r = '0;
        r.kind = k;
        r.last = l;
        return r;
    endfunction

    // control
    always_comb begin
        state_next = state_reg;
        head_next = head_reg; tick_next = tick_reg; early_next = early_reg;
        idx_next = idx_reg; cur_next = cur_reg; prev_next = prev_reg;
        dl_next = dl_reg; pdl_next = pdl_reg; sw_next = sw_reg; cnt_next = cnt_reg;
        pend_next = pend_reg;
        res_next = res_reg; mv_next = mv_reg && !m_tready;
        ds_we = 1'b0; ds_wa = '0; ds_wd = '0; ds_ra = cur_reg;
        qv_we = 1'b0; qv_wa = '0; qv_wd = '0; qv_ra = cur_reg;
        st_we = 1'b0; st_wa = '0; st_wd = '0;
        case (state_reg)
            S_INIT: begin
                ds_we = 1'b1;
                ds_wa = init_reg[AW-1:0];
                ds_wd = (init_reg == '0) ? {stt_pkg::NEVER, AW'(0)} : '0;
                if (init_reg == (AW+1)'(NUM_TIMERS - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_OUT;
                    pend_next = mk(stt_pkg::K_REJECT, 1'b1);
                    case (in_op)
                        stt_pkg::OP_ALLOC: begin
                            if (free_any) begin
                                st_we = 1'b1; st_wa = free_idx; st_wd = stt_pkg::ST_ALLOC;
                                pend_next = mk(stt_pkg::K_ALLOC, 1'b1);
                                pend_next.slot = 5'(free_idx);
                            end else begin
                                pend_next = mk(stt_pkg::K_FAIL, 1'b1);
                            end
                        end
                        stt_pkg::OP_RELEASE: begin
                            if (in_ok && status_reg[ti_a] != stt_pkg::ST_RUN) begin
                                st_we = 1'b1; st_wa = ti_a; st_wd = stt_pkg::ST_FREE;
                                pend_next = mk(stt_pkg::K_DONE, 1'b1);
                            end
                        end
                        stt_pkg::OP_BIND: begin
                            if (in_ok) begin
                                qv_we = 1'b1; qv_wa = ti_a; qv_wd = {in_dest, in_pay};
                                pend_next = mk(stt_pkg::K_DONE, 1'b1);
                            end
                        end
                        stt_pkg::OP_ARM: begin
                            if (in_ok && status_reg[ti_a] == stt_pkg::ST_ALLOC) begin
                                dl_next = carry ? stt_pkg::NEVER : sum;
                                st_we = 1'b1; st_wa = ti_a; st_wd = stt_pkg::ST_RUN;
                                idx_next = ti_a;
                                cur_next = head_reg;
                                ds_ra = head_reg;
                                cnt_next = '0;
                                state_next = S_AH;
                            end
                        end
                        stt_pkg::OP_TICK: begin
                            tick_next = (tick_reg < stt_pkg::COUNT_MAX) ?
                                        tick_reg + 32'd1 : tick_reg;
                            sw_next = 1'b0;
                            cnt_next = '0;
                            cur_next = head_reg;
                            if (early_reg <= ((tick_reg < stt_pkg::COUNT_MAX) ?
                                              tick_reg + 32'd1 : tick_reg))
                                state_next = S_TR;
                            else
                                state_next = S_TDONE;
                        end
                        default: ;
                    endcase
                end
            end
            S_AH: begin
                // head deadline and successor in ds_rd
                if (dl_reg <= rd_dl) begin
                    ds_we = 1'b1; ds_wa = idx_reg; ds_wd = {dl_reg, cur_reg};
                    head_next = idx_reg;
                    early_next = dl_reg;
                    pend_next = mk(stt_pkg::K_DONE, 1'b1);
                    state_next = S_OUT;
                end else begin
                    prev_next = cur_reg;
                    pdl_next = rd_dl;
                    cur_next = rd_sc;
                    ds_ra = rd_sc;
                    cnt_next = 7'd1;
                    state_next = S_AD;
                end
            end
            S_AD: begin
                if (dl_reg <= rd_dl) begin
                    ds_we = 1'b1; ds_wa = prev_reg; ds_wd = {pdl_reg, idx_reg};
                    state_next = S_AS;
                end else if (cnt_reg >= 7'(NUM_TIMERS)) begin
                    pend_next = mk(stt_pkg::K_DONE, 1'b1);
                    state_next = S_OUT;
                end else begin
                    prev_next = cur_reg;
                    pdl_next = rd_dl;
                    cur_next = rd_sc;
                    ds_ra = rd_sc;
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            S_AS: begin
                ds_we = 1'b1; ds_wa = idx_reg; ds_wd = {dl_reg, cur_reg};
                pend_next = mk(stt_pkg::K_DONE, 1'b1);
                state_next = S_OUT;
            end
            S_TR: begin
                // read deadline, successor and binding of cur
                ds_ra = cur_reg; qv_ra = cur_reg;
                state_next = S_TD;
            end
            S_TD: begin
                if (rd_dl > tick_reg || cnt_reg >= 7'(NUM_TIMERS)) begin
                    head_next = cur_reg;
                    early_next = rd_dl;
                    state_next = sw_reg ? S_TSW : S_TDONE;
                end else if (32'(cur_reg) == 32'(task_reg) && task_reg != 5'd0) begin
                    st_we = 1'b1; st_wa = cur_reg; st_wd = stt_pkg::ST_ALLOC;
                    sw_next = 1'b1;
                    cnt_next = cnt_reg + 7'd1;
                    cur_next = rd_sc;
                    state_next = S_TR;
                end else if (out_free) begin
                    st_we = 1'b1; st_wa = cur_reg; st_wd = stt_pkg::ST_ALLOC;
                    res_next = mk(stt_pkg::K_EVENT, 1'b0);
                    res_next.slot = 5'(cur_reg);
                    res_next.target_queue = qv_rd[35:32];
                    res_next.event_value = qv_rd[31:0];
                    mv_next = 1'b1;
                    cnt_next = cnt_reg + 7'd1;
                    cur_next = rd_sc;
                    state_next = S_TR;
                end else begin
                    state_next = S_TR;
                end
            end
            S_TSW: begin
                if (out_free) begin
                    res_next = mk(stt_pkg::K_SWITCH, 1'b0);
                    mv_next = 1'b1;
                    state_next = S_TDONE;
                end
            end
            S_TDONE: begin
                pend_next = mk(stt_pkg::K_DONE, 1'b1);
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    res_next = pend_reg;
                    mv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            init_reg <= '0;
            head_reg <= '0;
            tick_reg <= '0;
            early_reg <= stt_pkg::NEVER;
            task_reg <= '0;
            mv_reg <= 1'b0;
            sw_reg <= 1'b0;
            cnt_reg <= '0;
            for (int i = 0; i < NUM_TIMERS; i++)
                status_reg[i] <= (i == 0) ? stt_pkg::ST_RUN : stt_pkg::ST_FREE;
        end else begin
            state_reg <= state_next;
            init_reg <= init_reg + (AW+1)'(1);
            head_reg <= head_next;
            tick_reg <= tick_next;
            early_reg <= early_next;
            mv_reg <= mv_next;
            sw_reg <= sw_next;
            cnt_reg <= cnt_next;
            if (cfg_we) task_reg <= cfg_wdata;
            if (st_we) status_reg[st_wa] <= st_wd;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        cur_reg <= cur_next;
        prev_reg <= prev_next;
        dl_reg <= dl_next;
        pdl_reg <= pdl_next;
        res_reg <= res_next;
        pend_reg <= pend_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {4'd0, res_reg.event_value, res_reg.target_queue,
                       res_reg.slot, res_reg.kind};

    // the sentinel entry is never anything but running
    a_sentinel: assert property (@(posedge aclk) disable iff (!aresetn)
        status_reg[0] == stt_pkg::ST_RUN) else $error("sentinel left running state");
    // no item taken while a walk is in progress
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TD || state_reg == S_AD) |-> !s_tready)
        else $error("ready during list walk");
    // a held result beat stays until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat dropped");
endmodule

// ===== tb/sorted_timeout_timer_pool_test.sv =====
// self-checking testbench of the sorted timeout timer pool
`timescale 1ns / 1ps
module sorted_timeout_timer_pool_test;
    localparam int POOL       = 32;
    localparam int CYCLE_CAP  = 1000000;
    localparam int SETTLE     = 100;
    localparam int HOLD_LEN   = 600;
    localparam int PHASE_LEN  = 109;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    sorted_timeout_timer_pool #(.NUM_TIMERS(POOL)) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // shadow copy of the timer pool
    logic [1:0]  ent_status [POOL];
    logic [31:0] ent_deadline [POOL];
    logic [31:0] ent_value [POOL];
    logic [3:0]  ent_queue [POOL];
    logic [4:0]  ent_next [POOL];
    bit          ent_bound [POOL];
    logic [4:0]  head_idx;
    logic [31:0] now_ticks;
    logic [31:0] soonest;
    logic [4:0]  switch_timer;

    logic [79:0]      pending_beats [$];
    stt_pkg::result_t expected_results [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int cycles = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;

    function automatic stt_pkg::result_t mk(logic [2:0] kind, logic [4:0] slot,
                                            logic [3:0] q, logic [31:0] v, logic lst);
        stt_pkg::result_t r;
        r.kind = kind;
        r.slot = slot;
        r.target_queue = q;
        r.event_value = v;
        r.last = lst;
        return r;
    endfunction

    // insert a timer ahead of equal deadlines
    task automatic link_timer(input logic [4:0] idx);
        logic [31:0] d;
        logic [4:0]  prv;
        logic [4:0]  cur;
        d = ent_deadline[idx];
        cur = head_idx;
        if (d <= ent_deadline[cur]) begin
            ent_next[idx] = cur;
            head_idx = idx;
            soonest = d;
            return;
        end
        for (int n = 0; n < POOL; n++) begin
            prv = cur;
            cur = ent_next[prv];
            if (d <= ent_deadline[cur]) begin
                ent_next[prv] = idx;
                ent_next[idx] = cur;
                return;
            end
        end
    endtask

    // predict the result beats of one item and queue the item
    task automatic timer_pool_step(input logic [79:0] item);
        logic [2:0]  op;
        logic [4:0]  ti;
        logic [31:0] dly;
        logic [31:0] d;
        logic [4:0]  cur;
        bit          found;
        bit          sw;
        op = item[2:0];
        ti = item[7:3];
        dly = item[39:8];
        found = 0;
        sw = 0;
        pending_beats.push_back(item);
        case (op)
            stt_pkg::OP_ALLOC: begin
                for (int i = 0; i < POOL; i++) begin
                    if (!found && ent_status[i] == stt_pkg::ST_FREE) begin
                        found = 1;
                        ent_status[i] = stt_pkg::ST_ALLOC;
                        expected_results.push_back(mk(stt_pkg::K_ALLOC, 5'(i), 4'd0,
                                                      32'd0, 1'b1));
                    end
                end
                if (!found)
                    expected_results.push_back(mk(stt_pkg::K_FAIL, 5'd0, 4'd0, 32'd0, 1'b1));
            end
            stt_pkg::OP_RELEASE: begin
                if (ent_status[ti] == stt_pkg::ST_RUN) begin
                    expected_results.push_back(mk(stt_pkg::K_REJECT, 5'd0, 4'd0, 32'd0, 1'b1));
                end else begin
                    ent_status[ti] = stt_pkg::ST_FREE;
                    expected_results.push_back(mk(stt_pkg::K_DONE, 5'd0, 4'd0, 32'd0, 1'b1));
                end
            end
            stt_pkg::OP_BIND: begin
                ent_queue[ti] = item[43:40];
                ent_value[ti] = item[75:44];
                ent_bound[ti] = 1;
                expected_results.push_back(mk(stt_pkg::K_DONE, 5'd0, 4'd0, 32'd0, 1'b1));
            end
            stt_pkg::OP_ARM: begin
                if (ent_status[ti] != stt_pkg::ST_ALLOC) begin
                    expected_results.push_back(mk(stt_pkg::K_REJECT, 5'd0, 4'd0, 32'd0, 1'b1));
                end else begin
                    d = dly + now_ticks;
                    if (d < dly) d = stt_pkg::NEVER;
                    ent_deadline[ti] = d;
                    ent_status[ti] = stt_pkg::ST_RUN;
                    link_timer(ti);
                    expected_results.push_back(mk(stt_pkg::K_DONE, 5'd0, 4'd0, 32'd0, 1'b1));
                end
            end
            stt_pkg::OP_TICK: begin
                if (now_ticks < stt_pkg::COUNT_MAX) now_ticks = now_ticks + 1;
                if (soonest <= now_ticks) begin
                    cur = head_idx;
                    for (int n = 0; n < POOL; n++) begin
                        if (ent_deadline[cur] > now_ticks) break;
                        ent_status[cur] = stt_pkg::ST_ALLOC;
                        if (switch_timer != 0 && cur == switch_timer) sw = 1;
                        else expected_results.push_back(mk(stt_pkg::K_EVENT, cur,
                                                           ent_queue[cur],
                                                           ent_value[cur], 1'b0));
                        cur = ent_next[cur];
                    end
                    head_idx = cur;
                    soonest = ent_deadline[cur];
                    if (sw)
                        expected_results.push_back(mk(stt_pkg::K_SWITCH, 5'd0, 4'd0,
                                                      32'd0, 1'b0));
                end
                expected_results.push_back(mk(stt_pkg::K_DONE, 5'd0, 4'd0, 32'd0, 1'b1));
            end
            default: begin
                expected_results.push_back(mk(stt_pkg::K_REJECT, 5'd0, 4'd0, 32'd0, 1'b1));
            end
        endcase
    endtask

    function automatic logic [79:0] pack_item(logic [2:0] op, logic [4:0] ti, logic [31:0] dly,
                                              logic [3:0] dst, logic [31:0] pay);
        return {4'd0, pay, dst, dly, ti, op};
    endfunction

    // random item, mostly aimed at entries in use; an unbound timer is armed only via a random stray index
    task automatic random_item();
        int          r;
        int          hi;
        logic [2:0]  op;
        logic [4:0]  ti;
        logic [31:0] dly;
        hi = 1;
        for (int i = 0; i < POOL; i++) if (ent_status[i] != stt_pkg::ST_FREE) hi = i + 1;
        if (hi > POOL - 1) hi = POOL - 1;
        r = $urandom_range(99);
        ti = 5'($urandom_range(hi, 0));
        dly = $urandom;
        if (r < 14) op = stt_pkg::OP_ALLOC;
        else if (r < 26) op = stt_pkg::OP_RELEASE;
        else if (r < 44) op = stt_pkg::OP_BIND;
        else if (r < 68) begin
            op = stt_pkg::OP_ARM;
            r = $urandom_range(99);
            if (r == 0) dly = $urandom;
            else if (r < 20) dly = $urandom_range(3, 0);
            else dly = $urandom_range(40, 0);
            if (ent_status[ti] == stt_pkg::ST_ALLOC && !ent_bound[ti]) op = stt_pkg::OP_BIND;
            if (ent_status[ti] != stt_pkg::ST_ALLOC && $urandom_range(3) == 0)
                ti = 5'($urandom);
        end else if (r < 96) op = stt_pkg::OP_TICK;
        else begin
            op = 3'($urandom_range(7, 5));
            ti = 5'($urandom);
        end
        timer_pool_step(pack_item(op, ti, dly, 4'($urandom), $urandom));
    endtask

    // wait for every beat to go in and every result to come back
    task automatic drain();
        while (pending_beats.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_switch_timer(input logic [4:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        switch_timer = v;
    endtask

    // driver: one nonblocking update of valid and data per edge
    always @(posedge aclk) begin
        logic        nv;
        logic [79:0] nd;
        nv = s_tvalid;
        nd = s_tdata;
        if (!aresetn) begin
            nv = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                void'(pending_beats.pop_front());
                nv = 1'b0;
            end
            if (!nv && pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nv = 1'b1;
                nd = pending_beats[0];
            end
        end
        s_tvalid <= nv;
        s_tdata <= nd;
    end

    // long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_LEN;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: check each result beat against the oldest prediction
    always @(posedge aclk) begin
        stt_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: tdata %h tlast %b", m_tdata, m_tlast);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[2:0] !== want.kind || m_tdata[7:3] !== want.slot ||
                    m_tdata[11:8] !== want.target_queue ||
                    m_tdata[43:12] !== want.event_value || m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch: expected kind %0d slot %0d queue %0d %s",
                                 want.kind, want.slot, want.target_queue, "");
                        $display("  expected value %h last %b", want.event_value, want.last);
                        $display("  got kind %0d slot %0d queue %0d value %h last %b",
                                 m_tdata[2:0], m_tdata[7:3], m_tdata[11:8],
                                 m_tdata[43:12], m_tlast);
                    end
                end
            end
        end
        m_tready <= aresetn && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // stimulus
    initial begin
        for (int i = 0; i < POOL; i++) begin
            ent_status[i] = stt_pkg::ST_FREE;
            ent_deadline[i] = '0;
            ent_value[i] = '0;
            ent_queue[i] = '0;
            ent_next[i] = '0;
            ent_bound[i] = 0;
        end
        ent_status[0] = stt_pkg::ST_RUN;
        ent_deadline[0] = stt_pkg::NEVER;
        head_idx = '0;
        now_ticks = '0;
        soonest = stt_pkg::NEVER;
        switch_timer = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: operations, field extremes, special cases
        timer_pool_step(pack_item(stt_pkg::OP_ALLOC, 5'd0, 32'd0, 4'd0, 32'd0));
        timer_pool_step(pack_item(stt_pkg::OP_ALLOC, 5'd31, 32'hffffffff, 4'd15, 32'hffffffff));
        timer_pool_step(pack_item(stt_pkg::OP_ALLOC, 5'd0, 32'd0, 4'd0, 32'd0));
        timer_pool_step(pack_item(stt_pkg::OP_BIND, 5'd1, 32'd0, 4'd15, 32'h80000000));
        timer_pool_step(pack_item(stt_pkg::OP_BIND, 5'd2, 32'd0, 4'd0, 32'h7fffffff));
        timer_pool_step(pack_item(stt_pkg::OP_BIND, 5'd3, 32'd0, 4'd9, 32'h12345678));
        timer_pool_step(pack_item(stt_pkg::OP_ARM, 5'd1, 32'd0, 4'd0, 32'd0));
        timer_pool_step(pack_item(stt_pkg::OP_ARM, 5'd2, 32'd2, 4'd0, 32'd0));
        // maximum delay gives a deadline that never expires
        timer_pool_step(pack_item(stt_pkg::OP_ARM, 5'd3, 32'hffffffff, 4'd0, 32'd0));
        timer_pool_step(pack_item(stt_pkg::OP_TICK, 5'd0, 32'd0, 4'd0, 32'd0));
        // release of running timer and of the sentinel is refused
        timer_pool_step(pack_item(stt_pkg::OP_RELEASE, 5'd3, 32'd0, 4'd0, 32'd0));
        timer_pool_step(pack_item(stt_pkg::OP_RELEASE, 5'd0, 32'd0, 4'd0, 32'd0));
        // release of a free entry is accepted
        timer_pool_step(pack_item(stt_pkg::OP_RELEASE, 5'd30, 32'd0, 4'd0, 32'd0));
        // arm of free, sentinel and running entries is refused
        timer_pool_step(pack_item(stt_pkg::OP_ARM, 5'd30, 32'd1, 4'd0, 32'd0));
        timer_pool_step(pack_item(stt_pkg::OP_ARM, 5'd0, 32'd1, 4'd0, 32'd0));
        timer_pool_step(pack_item(stt_pkg::OP_ARM, 5'd2, 32'd1, 4'd0, 32'd0));
        // rebinding a running timer changes what it delivers
        timer_pool_step(pack_item(stt_pkg::OP_BIND, 5'd2, 32'd0, 4'd5, 32'hdeadbeef));
        timer_pool_step(pack_item(3'd5, 5'd0, 32'd0, 4'd0, 32'd0));
        timer_pool_step(pack_item(3'd6, 5'd0, 32'd0, 4'd0, 32'd0));
        timer_pool_step(pack_item(3'd7, 5'd31, 32'hffffffff, 4'd15, 32'hffffffff));
        // equal deadlines
        timer_pool_step(pack_item(stt_pkg::OP_ARM, 5'd1, 32'd1, 4'd0, 32'd0));
        timer_pool_step(pack_item(stt_pkg::OP_TICK, 5'd0, 32'd0, 4'd0, 32'd0));
        timer_pool_step(pack_item(stt_pkg::OP_TICK, 5'd0, 32'd0, 4'd0, 32'd0));
        drain();

        // random phases, each with its own task timer setting (0 turns it off) and idling
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin write_switch_timer(5'd1);  send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin write_switch_timer(5'd0);  send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin write_switch_timer(5'd2);  send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin
                    write_switch_timer(5'd31); send_idle_pct = 16; recv_stall_pct = 16;
                end
            endcase
            if (ph == 0) hold_token = hold_token + 1;
            for (int n = 0; n < PHASE_LEN; n++) begin
                random_item();
                // sender pause until all results are back
                if (ph == 1 && n == PHASE_LEN / 2) drain();
            end
            drain();
        end

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
